// ----- src/median_cut_palette_builder_defines.svh -----
// Assertion macros shared by the median-cut palette builder.
`ifndef MEDIAN_CUT_PALETTE_BUILDER_DEFINES_SVH
`define MEDIAN_CUT_PALETTE_BUILDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCPB_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCPB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/mcpb_pkg.sv -----
// Types, constants and helpers of the median-cut palette builder.
package mcpb_pkg;

   localparam int MAX_PIXELS_DEF  = 4096;
   localparam int MAX_PALETTE_DEF = 256;
   localparam int LEVELS          = 256;
   localparam int CHANNELS        = 3;
   localparam logic [8:0] MAX_COLORS_RESET = 9'd256;

   localparam logic [1:0] MODE_LOAD    = 2'd0;
   localparam logic [1:0] MODE_PALETTE = 2'd1;
   localparam logic [1:0] MODE_INDEX   = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        last;
      logic [11:0] address;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] color_index;
      logic [8:0] color_count;
   } rsp_type;

   function automatic logic [7:0] chan(input logic [23:0] c, input logic [1:0] k);
      logic [7:0] v;
      case (k)
         2'd0:    v = c[23:16];
         2'd1:    v = c[15:8];
         default: v = c[7:0];
      endcase
      return v;
   endfunction

endpackage

// ----- src/median_cut_palette_builder.sv -----
// Median-cut palette builder: pixel store, cut sequencer and read-back.
//
// Usage: requests enter on req (start high while busy is low). Mode load
// stores one pixel per request; a pixel with last set also starts the cut,
// and busy stays high until the cut is done. The cut then gives one result
// on rsp, marked by rsp_valid for one cycle, carrying the color count.
// Mode palette and mode index read back a palette entry or a pixel's index;
// the request passes through a wait state, in which busy is high for one
// cycle, and the result is registered as it ends. Mode 3 is ignored.
// The cut is paced by the sequencer walking the pixel memories: it copies
// the pixels, measures the bounds of each new box, sorts the split box
// through a histogram and prefix sum per split, sums the pixels of each
// box and divides them for the palette means, and for each of n pixels
// searches all n pixels for the highest palette entry of a match.
// The receiver cannot stall; each result is present for exactly one cycle.
// The csr channel writes max_colors and is always ready; write it only idle.
// Reset clears the pixel count, color count and control state; the stores
// keep their contents, and reads beyond the last cut return zeros.
module median_cut_palette_builder
   import mcpb_pkg::*;
#(
   parameter int MAX_PIXELS  = MAX_PIXELS_DEF,
   parameter int MAX_PALETTE = MAX_PALETTE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req,
   output logic       rsp_valid,
   output rsp_type    rsp,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [8:0] csr_data
);

`include "median_cut_palette_builder_defines.svh"

   localparam int AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CW  = $clog2(MAX_PIXELS + 1);
   localparam int PW  = $clog2(MAX_PALETTE);
   localparam int NBW = $clog2(MAX_PALETTE + 1);
   localparam int SW  = CW + 8;
   localparam int KW  = $clog2(LEVELS + 1);

   localparam logic [5:0] S_IDLE      = 6'd0;
   localparam logic [5:0] S_RD_WAIT   = 6'd1;
   localparam logic [5:0] S_COPY_RD   = 6'd2;
   localparam logic [5:0] S_COPY_WR   = 6'd3;
   localparam logic [5:0] S_INIT_BOX  = 6'd4;
   localparam logic [5:0] S_MEAS_RD   = 6'd5;
   localparam logic [5:0] S_MEAS_EV   = 6'd6;
   localparam logic [5:0] S_MEAS_END  = 6'd7;
   localparam logic [5:0] S_SPLIT_TOP = 6'd8;
   localparam logic [5:0] S_PICK_RD   = 6'd9;
   localparam logic [5:0] S_PICK_EV   = 6'd10;
   localparam logic [5:0] S_SPLIT_CHK = 6'd11;
   localparam logic [5:0] S_CLR       = 6'd12;
   localparam logic [5:0] S_HIST_RD   = 6'd13;
   localparam logic [5:0] S_HIST_KEY  = 6'd14;
   localparam logic [5:0] S_HIST_WR   = 6'd15;
   localparam logic [5:0] S_PFX_RD    = 6'd16;
   localparam logic [5:0] S_PFX_WR    = 6'd17;
   localparam logic [5:0] S_DST_RD    = 6'd18;
   localparam logic [5:0] S_DST_KEY   = 6'd19;
   localparam logic [5:0] S_DST_WR    = 6'd20;
   localparam logic [5:0] S_CPY_RD    = 6'd21;
   localparam logic [5:0] S_CPY_WR    = 6'd22;
   localparam logic [5:0] S_SHF_RD    = 6'd23;
   localparam logic [5:0] S_SHF_WR    = 6'd24;
   localparam logic [5:0] S_NEW1      = 6'd25;
   localparam logic [5:0] S_NEW2      = 6'd26;
   localparam logic [5:0] S_SPLIT_INC = 6'd27;
   localparam logic [5:0] S_PAL_TOP   = 6'd28;
   localparam logic [5:0] S_PAL_SUM   = 6'd29;
   localparam logic [5:0] S_SUM_RD    = 6'd30;
   localparam logic [5:0] S_SUM_EV    = 6'd31;
   localparam logic [5:0] S_DIV_INIT  = 6'd32;
   localparam logic [5:0] S_DIV_STEP  = 6'd33;
   localparam logic [5:0] S_PAL_WR    = 6'd34;
   localparam logic [5:0] S_IDX_TOP   = 6'd35;
   localparam logic [5:0] S_IDX_LD    = 6'd36;
   localparam logic [5:0] S_IDX_RUN   = 6'd37;
   localparam logic [5:0] S_DONE      = 6'd38;

   typedef struct packed {
      logic [AW-1:0] start;
      logic [CW-1:0] len;
   } range_type;

   typedef logic [1:0][2:0][7:0] bounds_type;

   logic [23:0]      orig_mem    [MAX_PIXELS];
   logic [23:0]      work_mem    [MAX_PIXELS];
   logic [23:0]      scratch_mem [MAX_PIXELS];
   logic [7:0]       pospal_mem  [MAX_PIXELS];
   logic [7:0]       index_mem   [MAX_PIXELS];
   logic [CW-1:0]    count_mem   [LEVELS + 1];
   range_type        range_mem   [MAX_PALETTE];
   bounds_type       bounds_mem  [MAX_PALETTE];
   logic [23:0]      palette_mem [MAX_PALETTE];

   logic             orig_we, work_we, scratch_we, pospal_we, index_we;
   logic             count_we, range_we, bounds_we, palette_we;
   logic [AW-1:0]    orig_wa, orig_ra, work_wa, work_ra, scratch_wa, scratch_ra;
   logic [AW-1:0]    pospal_wa, pospal_ra, index_wa, index_ra;
   logic [KW-1:0]    count_wa, count_ra;
   logic [PW-1:0]    range_wa, range_ra, bounds_wa, bounds_ra, palette_wa, palette_ra;
   logic [23:0]      orig_wd, work_wd, scratch_wd, palette_wd;
   logic [7:0]       pospal_wd, index_wd;
   logic [CW-1:0]    count_wd;
   range_type        range_wd;
   bounds_type       bounds_wd;

   logic [23:0]      orig_rd_ff, work_rd_ff, scratch_rd_ff, palette_rd_ff;
   logic [7:0]       pospal_rd_ff, index_rd_ff;
   logic [CW-1:0]    count_rd_ff;
   range_type        range_rd_ff;
   bounds_type       bounds_rd_ff;

   logic [5:0]       state_ff, ret_ff;
   logic [CW-1:0]    i_ff, j_ff, n_ff, pixel_total_ff, cut_pixels_ff, acc_ff;
   logic [CW-1:0]    tlen_ff, mlen_ff;
   logic [KW-1:0]    k_ff, key_ff;
   logic [NBW-1:0]   b_ff, p_ff, nb_ff, limit_ff;
   logic [PW-1:0]    t_ff, mb_ff;
   logic [AW-1:0]    tstart_ff, mstart_ff;
   logic [1:0]       axis_ff, ch_ff;
   logic             found_ff, ivld_ff, rd_ok_ff, rd_pal_ff;
   logic [7:0]       bside_ff, q_ff, bestp_ff;
   logic [2:0]       bit_ff;
   logic [2:0][7:0]  lo_ff, hi_ff, rgb_ff;
   logic [2:0][SW-1:0] sum_ff;
   logic [SW-1:0]    rem_ff, dvs_ff;
   logic [23:0]      pix_ff, cur_ff;
   logic [MAX_PALETTE-1:0] used_ff;
   logic [8:0]       color_total_ff, max_colors_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic [AW-1:0]    tpos, mpos;
   logic [7:0]       d0, d1, d2, side_c;
   logic [1:0]       axis_c;
   logic [CW-1:0]    half_c;
   logic             ge_c;
   logic [7:0]       qn_c;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign csr_ready = 1'b1;

   assign tpos   = AW'(32'(tstart_ff) + 32'(i_ff));
   assign mpos   = AW'(32'(mstart_ff) + 32'(i_ff));
   assign half_c = CW'((32'(tlen_ff) + 1) >> 1);
   assign ge_c   = (rem_ff >= dvs_ff);
   assign qn_c   = ge_c ? (q_ff | (8'd1 << bit_ff)) : q_ff;

   always_comb begin
      d0 = bounds_rd_ff[1][0] - bounds_rd_ff[0][0];
      d1 = bounds_rd_ff[1][1] - bounds_rd_ff[0][1];
      d2 = bounds_rd_ff[1][2] - bounds_rd_ff[0][2];
      side_c = d0;
      axis_c = 2'd0;
      if (d1 > side_c) begin
         side_c = d1;
         axis_c = 2'd1;
      end
      if (d2 > side_c) begin
         side_c = d2;
         axis_c = 2'd2;
      end
   end

   always_comb begin
      orig_we = 1'b0; work_we = 1'b0; scratch_we = 1'b0; pospal_we = 1'b0;
      index_we = 1'b0; count_we = 1'b0; range_we = 1'b0; bounds_we = 1'b0;
      palette_we = 1'b0;
      orig_wa = '0; orig_ra = '0; work_wa = '0; work_ra = '0;
      scratch_wa = '0; scratch_ra = '0; pospal_wa = '0; pospal_ra = '0;
      index_wa = '0; index_ra = '0; count_wa = '0; count_ra = '0;
      range_wa = '0; range_ra = '0; bounds_wa = '0; bounds_ra = '0;
      palette_wa = '0; palette_ra = '0;
      orig_wd = {req.red, req.green, req.blue};
      work_wd = orig_rd_ff; scratch_wd = pix_ff; palette_wd = rgb_ff;
      pospal_wd = 8'(p_ff); index_wd = bestp_ff;
      count_wd = '0; range_wd = '0; bounds_wd = {hi_ff, lo_ff};
      unique case (state_ff)
         S_IDLE: begin
            orig_wa    = AW'(pixel_total_ff);
            orig_we    = start && (req.mode == MODE_LOAD) &&
                         (32'(pixel_total_ff) < MAX_PIXELS);
            palette_ra = PW'(req.address);
            index_ra   = AW'(req.address);
         end
         S_COPY_RD:  orig_ra = AW'(i_ff);
         S_COPY_WR: begin
            work_we = 1'b1;
            work_wa = AW'(i_ff);
         end
         S_INIT_BOX: begin
            range_we = 1'b1;
            range_wd = '{start: '0, len: n_ff};
         end
         S_MEAS_RD:  work_ra = mpos;
         S_MEAS_END: begin
            bounds_we = 1'b1;
            bounds_wa = mb_ff;
         end
         S_PICK_RD: begin
            range_ra  = PW'(b_ff);
            bounds_ra = PW'(b_ff);
         end
         S_CLR: begin
            count_we = 1'b1;
            count_wa = k_ff;
         end
         S_HIST_RD:  work_ra = tpos;
         S_HIST_KEY: count_ra = KW'(chan(work_rd_ff, axis_ff)) + KW'(1);
         S_HIST_WR: begin
            count_we = 1'b1;
            count_wa = key_ff;
            count_wd = count_rd_ff + CW'(1);
         end
         S_PFX_RD:   count_ra = k_ff;
         S_PFX_WR: begin
            count_we = 1'b1;
            count_wa = k_ff;
            count_wd = acc_ff + count_rd_ff;
         end
         S_DST_RD:   work_ra = tpos;
         S_DST_KEY:  count_ra = KW'(chan(work_rd_ff, axis_ff));
         S_DST_WR: begin
            scratch_we = 1'b1;
            scratch_wa = AW'(count_rd_ff);
            count_we   = 1'b1;
            count_wa   = key_ff;
            count_wd   = count_rd_ff + CW'(1);
         end
         S_CPY_RD:   scratch_ra = AW'(i_ff);
         S_CPY_WR: begin
            work_we = 1'b1;
            work_wa = tpos;
            work_wd = scratch_rd_ff;
         end
         S_SHF_RD: begin
            range_ra  = PW'(32'(b_ff) + 1);
            bounds_ra = PW'(32'(b_ff) + 1);
         end
         S_SHF_WR: begin
            range_we  = 1'b1;
            range_wa  = PW'(b_ff);
            range_wd  = range_rd_ff;
            bounds_we = 1'b1;
            bounds_wa = PW'(b_ff);
            bounds_wd = bounds_rd_ff;
         end
         S_NEW1: begin
            range_we = 1'b1;
            range_wa = PW'(32'(nb_ff) - 1);
            range_wd = '{start: tstart_ff, len: half_c};
         end
         S_NEW2: begin
            range_we = 1'b1;
            range_wa = PW'(nb_ff);
            range_wd = '{start: AW'(32'(tstart_ff) + 32'(half_c)), len: tlen_ff - half_c};
         end
         S_SUM_RD:   work_ra = tpos;
         S_SUM_EV: begin
            pospal_we = 1'b1;
            pospal_wa = tpos;
         end
         S_PAL_WR: begin
            palette_we = 1'b1;
            palette_wa = PW'(p_ff);
         end
         S_IDX_TOP:  orig_ra = AW'(i_ff);
         S_IDX_RUN: begin
            work_ra   = AW'(j_ff);
            pospal_ra = AW'(j_ff);
            index_wa  = AW'(i_ff);
            index_we  = (j_ff == n_ff) && !ivld_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (orig_we) orig_mem[orig_wa] <= orig_wd;
      orig_rd_ff <= orig_mem[orig_ra];
      if (work_we) work_mem[work_wa] <= work_wd;
      work_rd_ff <= work_mem[work_ra];
      if (scratch_we) scratch_mem[scratch_wa] <= scratch_wd;
      scratch_rd_ff <= scratch_mem[scratch_ra];
      if (pospal_we) pospal_mem[pospal_wa] <= pospal_wd;
      pospal_rd_ff <= pospal_mem[pospal_ra];
      if (index_we) index_mem[index_wa] <= index_wd;
      index_rd_ff <= index_mem[index_ra];
      if (count_we) count_mem[count_wa] <= count_wd;
      count_rd_ff <= count_mem[count_ra];
      if (range_we) range_mem[range_wa] <= range_wd;
      range_rd_ff <= range_mem[range_ra];
      if (bounds_we) bounds_mem[bounds_wa] <= bounds_wd;
      bounds_rd_ff <= bounds_mem[bounds_ra];
      if (palette_we) palette_mem[palette_wa] <= palette_wd;
      palette_rd_ff <= palette_mem[palette_ra];
   end

   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (csr_valid && csr_ready) begin
         max_colors_ff <= csr_data;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req.mode)
                  MODE_LOAD: begin
                     if (32'(pixel_total_ff) < MAX_PIXELS) begin
                        pixel_total_ff <= pixel_total_ff + CW'(1);
                     end
                     if (req.last) begin
                        n_ff <= (32'(pixel_total_ff) < MAX_PIXELS) ?
                                pixel_total_ff + CW'(1) : pixel_total_ff;
                        if (max_colors_ff == 9'd0) begin
                           limit_ff <= NBW'(1);
                        end else if (32'(max_colors_ff) > MAX_PALETTE) begin
                           limit_ff <= NBW'(MAX_PALETTE);
                        end else begin
                           limit_ff <= NBW'(max_colors_ff);
                        end
                        nb_ff    <= NBW'(1);
                        used_ff  <= '0;
                        i_ff     <= '0;
                        state_ff <= S_COPY_RD;
                     end
                  end
                  MODE_PALETTE: begin
                     rd_pal_ff <= 1'b1;
                     rd_ok_ff  <= 32'(req.address) < 32'(color_total_ff);
                     state_ff  <= S_RD_WAIT;
                  end
                  MODE_INDEX: begin
                     rd_pal_ff <= 1'b0;
                     rd_ok_ff  <= 32'(req.address) < 32'(cut_pixels_ff);
                     state_ff  <= S_RD_WAIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD_WAIT: begin
            rsp_valid_ff <= 1'b1;
            rsp_ff <= '0;
            rsp_ff.color_count <= color_total_ff;
            if (rd_ok_ff && rd_pal_ff) begin
               rsp_ff.out_red   <= palette_rd_ff[23:16];
               rsp_ff.out_green <= palette_rd_ff[15:8];
               rsp_ff.out_blue  <= palette_rd_ff[7:0];
            end else if (rd_ok_ff) begin
               rsp_ff.color_index <= index_rd_ff;
            end
            state_ff <= S_IDLE;
         end
         S_COPY_RD: state_ff <= S_COPY_WR;
         S_COPY_WR: begin
            i_ff <= i_ff + CW'(1);
            state_ff <= (32'(i_ff) + 1 < 32'(n_ff)) ? S_COPY_RD : S_INIT_BOX;
         end
         S_INIT_BOX: begin
            mb_ff     <= '0;
            mstart_ff <= '0;
            mlen_ff   <= n_ff;
            ret_ff    <= S_SPLIT_TOP;
            i_ff      <= '0;
            state_ff  <= S_MEAS_RD;
         end
         S_MEAS_RD: state_ff <= S_MEAS_EV;
         S_MEAS_EV: begin
            for (int k = 0; k < CHANNELS; k++) begin
               if (i_ff == '0 || chan(work_rd_ff, 2'(k)) < lo_ff[k]) begin
                  lo_ff[k] <= chan(work_rd_ff, 2'(k));
               end
               if (i_ff == '0 || chan(work_rd_ff, 2'(k)) > hi_ff[k]) begin
                  hi_ff[k] <= chan(work_rd_ff, 2'(k));
               end
            end
            i_ff <= i_ff + CW'(1);
            state_ff <= (32'(i_ff) + 1 < 32'(mlen_ff)) ? S_MEAS_RD : S_MEAS_END;
         end
         S_MEAS_END: state_ff <= ret_ff;
         S_SPLIT_TOP: begin
            b_ff     <= '0;
            found_ff <= 1'b0;
            if (nb_ff < limit_ff) begin
               ret_ff   <= S_SPLIT_CHK;
               state_ff <= S_PICK_RD;
            end else begin
               used_ff  <= '0;
               p_ff     <= '0;
               state_ff <= S_PAL_TOP;
            end
         end
         S_PICK_RD: state_ff <= S_PICK_EV;
         S_PICK_EV: begin
            if (!used_ff[PW'(b_ff)] && (!found_ff || side_c > bside_ff)) begin
               found_ff  <= 1'b1;
               bside_ff  <= side_c;
               axis_ff   <= axis_c;
               t_ff      <= PW'(b_ff);
               tstart_ff <= range_rd_ff.start;
               tlen_ff   <= range_rd_ff.len;
            end
            b_ff <= b_ff + NBW'(1);
            state_ff <= (32'(b_ff) + 1 < 32'(nb_ff)) ? S_PICK_RD : ret_ff;
         end
         S_SPLIT_CHK: begin
            k_ff <= '0;
            if (32'(tlen_ff) <= 1) begin
               used_ff  <= '0;
               p_ff     <= '0;
               state_ff <= S_PAL_TOP;
            end else begin
               state_ff <= S_CLR;
            end
         end
         S_CLR: begin
            k_ff <= k_ff + KW'(1);
            i_ff <= '0;
            state_ff <= (32'(k_ff) == LEVELS) ? S_HIST_RD : S_CLR;
         end
         S_HIST_RD: state_ff <= S_HIST_KEY;
         S_HIST_KEY: begin
            key_ff   <= KW'(chan(work_rd_ff, axis_ff)) + KW'(1);
            state_ff <= S_HIST_WR;
         end
         S_HIST_WR: begin
            i_ff   <= i_ff + CW'(1);
            k_ff   <= '0;
            acc_ff <= '0;
            state_ff <= (32'(i_ff) + 1 < 32'(tlen_ff)) ? S_HIST_RD : S_PFX_RD;
         end
         S_PFX_RD: state_ff <= S_PFX_WR;
         S_PFX_WR: begin
            acc_ff <= acc_ff + count_rd_ff;
            k_ff   <= k_ff + KW'(1);
            i_ff   <= '0;
            state_ff <= (32'(k_ff) == LEVELS) ? S_DST_RD : S_PFX_RD;
         end
         S_DST_RD: state_ff <= S_DST_KEY;
         S_DST_KEY: begin
            pix_ff   <= work_rd_ff;
            key_ff   <= KW'(chan(work_rd_ff, axis_ff));
            state_ff <= S_DST_WR;
         end
         S_DST_WR: begin
            if (32'(i_ff) + 1 < 32'(tlen_ff)) begin
               i_ff     <= i_ff + CW'(1);
               state_ff <= S_DST_RD;
            end else begin
               i_ff     <= '0;
               state_ff <= S_CPY_RD;
            end
         end
         S_CPY_RD: state_ff <= S_CPY_WR;
         S_CPY_WR: begin
            i_ff <= i_ff + CW'(1);
            b_ff <= NBW'(t_ff);
            if (32'(i_ff) + 1 < 32'(tlen_ff)) begin
               state_ff <= S_CPY_RD;
            end else begin
               state_ff <= (32'(t_ff) + 1 < 32'(nb_ff)) ? S_SHF_RD : S_NEW1;
            end
         end
         S_SHF_RD: state_ff <= S_SHF_WR;
         S_SHF_WR: begin
            b_ff <= b_ff + NBW'(1);
            state_ff <= (32'(b_ff) + 2 < 32'(nb_ff)) ? S_SHF_RD : S_NEW1;
         end
         S_NEW1: begin
            mb_ff     <= PW'(32'(nb_ff) - 1);
            mstart_ff <= tstart_ff;
            mlen_ff   <= half_c;
            ret_ff    <= S_NEW2;
            i_ff      <= '0;
            state_ff  <= S_MEAS_RD;
         end
         S_NEW2: begin
            mb_ff     <= PW'(nb_ff);
            mstart_ff <= AW'(32'(tstart_ff) + 32'(half_c));
            mlen_ff   <= tlen_ff - half_c;
            ret_ff    <= S_SPLIT_INC;
            i_ff      <= '0;
            state_ff  <= S_MEAS_RD;
         end
         S_SPLIT_INC: begin
            nb_ff    <= nb_ff + NBW'(1);
            state_ff <= S_SPLIT_TOP;
         end
         S_PAL_TOP: begin
            b_ff     <= '0;
            found_ff <= 1'b0;
            i_ff     <= '0;
            if (p_ff < nb_ff) begin
               ret_ff   <= S_PAL_SUM;
               state_ff <= S_PICK_RD;
            end else begin
               state_ff <= S_IDX_TOP;
            end
         end
         S_PAL_SUM: begin
            used_ff[t_ff] <= 1'b1;
            sum_ff   <= '0;
            i_ff     <= '0;
            state_ff <= S_SUM_RD;
         end
         S_SUM_RD: state_ff <= S_SUM_EV;
         S_SUM_EV: begin
            for (int k = 0; k < CHANNELS; k++) begin
               sum_ff[k] <= sum_ff[k] + SW'(chan(work_rd_ff, 2'(k)));
            end
            i_ff  <= i_ff + CW'(1);
            ch_ff <= 2'd0;
            state_ff <= (32'(i_ff) + 1 < 32'(tlen_ff)) ? S_SUM_RD : S_DIV_INIT;
         end
         S_DIV_INIT: begin
            rem_ff   <= sum_ff[ch_ff];
            dvs_ff   <= SW'(tlen_ff) << 7;
            q_ff     <= '0;
            bit_ff   <= 3'd7;
            state_ff <= S_DIV_STEP;
         end
         S_DIV_STEP: begin
            if (ge_c) begin
               rem_ff <= rem_ff - dvs_ff;
            end
            q_ff   <= qn_c;
            dvs_ff <= dvs_ff >> 1;
            bit_ff <= bit_ff - 3'd1;
            if (bit_ff == 3'd0) begin
               rgb_ff[2 - 32'(ch_ff)] <= qn_c;
               ch_ff    <= ch_ff + 2'd1;
               state_ff <= (ch_ff == 2'd2) ? S_PAL_WR : S_DIV_INIT;
            end
         end
         S_PAL_WR: begin
            p_ff     <= p_ff + NBW'(1);
            state_ff <= S_PAL_TOP;
         end
         S_IDX_TOP: state_ff <= (i_ff < n_ff) ? S_IDX_LD : S_DONE;
         S_IDX_LD: begin
            cur_ff   <= orig_rd_ff;
            j_ff     <= '0;
            bestp_ff <= '0;
            ivld_ff  <= 1'b0;
            state_ff <= S_IDX_RUN;
         end
         S_IDX_RUN: begin
            ivld_ff <= (j_ff < n_ff);
            if (j_ff < n_ff) begin
               j_ff <= j_ff + CW'(1);
            end
            if (ivld_ff && work_rd_ff == cur_ff && pospal_rd_ff > bestp_ff) begin
               bestp_ff <= pospal_rd_ff;
            end
            if (j_ff == n_ff && !ivld_ff) begin
               i_ff     <= i_ff + CW'(1);
               state_ff <= S_IDX_TOP;
            end
         end
         S_DONE: begin
            color_total_ff <= 9'(nb_ff);
            cut_pixels_ff  <= n_ff;
            pixel_total_ff <= '0;
            rsp_valid_ff   <= 1'b1;
            rsp_ff         <= '0;
            rsp_ff.color_count <= 9'(nb_ff);
            state_ff       <= S_IDLE;
         end
         default: state_ff <= S_IDLE;
      endcase
      if (reset) begin
         state_ff       <= S_IDLE;
         pixel_total_ff <= '0;
         color_total_ff <= '0;
         cut_pixels_ff  <= '0;
         max_colors_ff  <= MAX_COLORS_RESET;
         rsp_valid_ff   <= 1'b0;
      end
   end

   `MCPB_ASSERT_SAME(a_rsp_after_busy, rsp_valid, $past(busy), "result without busy")
   `MCPB_ASSERT_NEXT(a_last_starts_cut, start && !busy && req.mode == MODE_LOAD && req.last, busy, "cut did not start")
   `MCPB_ASSERT_SAME(a_box_limit, state_ff != S_IDLE && state_ff != S_RD_WAIT, nb_ff <= limit_ff && limit_ff != '0, "box count over limit")

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the median-cut palette builder with a built-in color predictor.
module testbench;
   import mcpb_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int TARGET_ITEMS = 950;

   typedef struct {
      req_type    request;
      bit         typed;
      rsp_type    result;
   } stim_row;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req;
   logic rsp_valid;
   rsp_type rsp;
   logic csr_valid;
   logic csr_ready;
   logic [8:0] csr_data;

   median_cut_palette_builder uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp(rsp), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   logic [23:0] pix_in [4096];
   logic [23:0] pts [4096];
   logic [23:0] sorted_pts [4096];
   logic [7:0] slot_entry [4096];
   logic [7:0] entry_of_pixel [4096];
   int box_first [256];
   int box_len [256];
   logic [7:0] box_lo [256][3];
   logic [7:0] box_hi [256][3];
   bit box_done [256];
   logic [23:0] palette [256];
   int pixels_loaded;
   int color_total;
   int pixels_cut;
   logic [8:0] colors_cap;

   rsp_type expected_results [$];
   int errors;
   int cycles;
   int items;
   int idle_pct;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [7:0] channel(input logic [23:0] c, input int k);
      return c[23 - 8 * k -: 8];
   endfunction

   function automatic void measure(input int b);
      logic [7:0] v;
      for (int k = 0; k < 3; k++) begin
         box_lo[b][k] = channel(pts[box_first[b]], k);
         box_hi[b][k] = box_lo[b][k];
      end
      for (int i = 1; i < box_len[b]; i++) begin
         for (int k = 0; k < 3; k++) begin
            v = channel(pts[box_first[b] + i], k);
            if (v < box_lo[b][k]) box_lo[b][k] = v;
            if (v > box_hi[b][k]) box_hi[b][k] = v;
         end
      end
   endfunction

   function automatic int longest_side(input int b, output int axis);
      int best;
      int d;
      best = box_hi[b][0] - box_lo[b][0];
      axis = 0;
      for (int k = 1; k < 3; k++) begin
         d = box_hi[b][k] - box_lo[b][k];
         if (d > best) begin
            best = d;
            axis = k;
         end
      end
      return best;
   endfunction

   function automatic int pick_box(input int nb, input bit skip_done);
      int top;
      int best;
      int s;
      int ax;
      top = -1;
      best = -1;
      for (int b = 0; b < nb; b++) begin
         if (!(skip_done && box_done[b])) begin
            s = longest_side(b, ax);
            if (s > best) begin
               best = s;
               top = b;
            end
         end
      end
      return top;
   endfunction

   function automatic void sort_on_channel(input int first, input int len, input int k);
      int count [257];
      int v;
      for (int i = 0; i <= 256; i++) count[i] = 0;
      for (int i = 0; i < len; i++) count[channel(pts[first + i], k) + 1]++;
      for (int i = 1; i <= 256; i++) count[i] += count[i - 1];
      for (int i = 0; i < len; i++) begin
         v = channel(pts[first + i], k);
         sorted_pts[count[v]] = pts[first + i];
         count[v]++;
      end
      for (int i = 0; i < len; i++) pts[first + i] = sorted_pts[i];
   endfunction

   function automatic void cut_image(input int n);
      int cap;
      int nb;
      int t;
      int axis;
      int first;
      int len;
      int half;
      int sum [3];
      logic [7:0] best;
      cap = colors_cap;
      if (cap < 1) cap = 1;
      if (cap > 256) cap = 256;
      for (int i = 0; i < n; i++) pts[i] = pix_in[i];
      box_first[0] = 0;
      box_len[0] = n;
      measure(0);
      nb = 1;
      while (nb < cap) begin
         t = pick_box(nb, 1'b0);
         first = box_first[t];
         len = box_len[t];
         if (len <= 1) break;
         void'(longest_side(t, axis));
         sort_on_channel(first, len, axis);
         half = (len + 1) / 2;
         for (int b = t; b < nb - 1; b++) begin
            box_first[b] = box_first[b + 1];
            box_len[b] = box_len[b + 1];
            box_lo[b] = box_lo[b + 1];
            box_hi[b] = box_hi[b + 1];
         end
         box_first[nb - 1] = first;
         box_len[nb - 1] = half;
         measure(nb - 1);
         box_first[nb] = first + half;
         box_len[nb] = len - half;
         measure(nb);
         nb++;
      end
      for (int b = 0; b < 256; b++) box_done[b] = 1'b0;
      for (int p = 0; p < nb; p++) begin
         t = pick_box(nb, 1'b1);
         box_done[t] = 1'b1;
         sum = '{0, 0, 0};
         for (int i = 0; i < box_len[t]; i++) begin
            for (int k = 0; k < 3; k++) sum[k] += channel(pts[box_first[t] + i], k);
            slot_entry[box_first[t] + i] = p[7:0];
         end
         for (int k = 0; k < 3; k++) palette[p][23 - 8 * k -: 8] = 8'(sum[k] / box_len[t]);
      end
      for (int i = 0; i < n; i++) begin
         best = 8'd0;
         for (int j = 0; j < n; j++)
            if (pts[j] == pix_in[i] && slot_entry[j] > best) best = slot_entry[j];
         entry_of_pixel[i] = best;
      end
      color_total = nb;
      pixels_cut = n;
      pixels_loaded = 0;
   endfunction

   function automatic bit predict_request(input req_type r, output rsp_type res);
      res = '0;
      if (r.mode == MODE_LOAD) begin
         if (pixels_loaded < 4096) begin
            pix_in[pixels_loaded] = {r.red, r.green, r.blue};
            pixels_loaded++;
         end
         if (!r.last) return 1'b0;
         cut_image(pixels_loaded);
      end else if (r.mode == MODE_PALETTE) begin
         if (r.address < color_total)
            {res.out_red, res.out_green, res.out_blue} = palette[r.address];
      end else if (r.mode == MODE_INDEX) begin
         if (r.address < pixels_cut) res.color_index = entry_of_pixel[r.address];
      end else begin
         return 1'b0;
      end
      res.color_count = 9'(color_total);
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, actual %p", $time, rsp);
         end else begin
            e = expected_results.pop_front();
            if (rsp.out_red !== e.out_red || rsp.out_green !== e.out_green ||
                rsp.out_blue !== e.out_blue || rsp.color_index !== e.color_index ||
                rsp.color_count !== e.color_count) begin
               errors++;
               $display("%0t: result mismatch, expected %p, actual %p", $time, e, rsp);
            end
         end
      end
   end

   task automatic send_request(input req_type r, input bit typed, input rsp_type typed_res);
      rsp_type res;
      start <= 1'b1;
      req <= r;
      do @(posedge clock); while (busy);
      if (predict_request(r, res)) expected_results.push_back(typed ? typed_res : res);
      items++;
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_colors_cap(input logic [8:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      colors_cap = value;
   endtask

   function automatic req_type make_req(input logic [1:0] mode, input logic [23:0] rgb,
                                        input logic last, input logic [11:0] address);
      req_type r;
      r.mode = mode;
      {r.red, r.green, r.blue} = rgb;
      r.last = last;
      r.address = address;
      return r;
   endfunction

   function automatic stim_row make_row(input req_type r, input bit typed,
                                        input logic [23:0] rgb, input logic [7:0] index,
                                        input logic [8:0] count);
      stim_row s;
      s.request = r;
      s.typed = typed;
      s.result = '0;
      {s.result.out_red, s.result.out_green, s.result.out_blue} = rgb;
      s.result.color_index = index;
      s.result.color_count = count;
      return s;
   endfunction

   function automatic logic [23:0] random_color(input int style);
      logic [23:0] c;
      c = $urandom();
      if (style == 0) begin
         for (int k = 0; k < 3; k++) c[23 - 8 * k -: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else if (style == 1) begin
         c = {8'($urandom_range(0, 3) * 16), 8'($urandom_range(0, 3) * 16),
              8'($urandom_range(0, 3) * 16)};
      end
      return c;
   endfunction

   stim_row directed [$];
   logic [8:0] cap_choices [7] = '{9'd1, 9'd2, 9'd3, 9'd0, 9'd511, 9'd256, 9'd5};

   initial begin
      int n;
      int style;
      int reads;
      int image;
      logic [11:0] addr;
      errors = 0;
      cycles = 0;
      items = 0;
      idle_pct = 21;
      colors_cap = MAX_COLORS_RESET;
      pixels_loaded = 0;
      color_total = 0;
      pixels_cut = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      directed.push_back(make_row(make_req(MODE_PALETTE, 0, 0, 0), 1, 0, 0, 0));
      directed.push_back(make_row(make_req(MODE_INDEX, 0, 0, 12'hFFF), 1, 0, 0, 0));
      directed.push_back(make_row(make_req(2'd3, 24'hFFFFFF, 1, 12'hFFF), 0, 0, 0, 0));
      directed.push_back(make_row(make_req(MODE_LOAD, 24'h000000, 0, 0), 0, 0, 0, 0));
      directed.push_back(make_row(make_req(MODE_LOAD, 24'hFFFFFF, 1, 0), 1, 0, 0, 2));
      directed.push_back(make_row(make_req(MODE_PALETTE, 0, 0, 0), 0, 0, 0, 0));
      directed.push_back(make_row(make_req(MODE_PALETTE, 0, 0, 1), 0, 0, 0, 0));
      directed.push_back(make_row(make_req(MODE_PALETTE, 0, 0, 2), 1, 0, 0, 2));
      directed.push_back(make_row(make_req(MODE_INDEX, 0, 0, 1), 0, 0, 0, 0));
      directed.push_back(make_row(make_req(MODE_INDEX, 0, 0, 2), 1, 0, 0, 2));
      directed.push_back(make_row(make_req(MODE_LOAD, 24'hFF0080, 1, 0), 1, 0, 0, 1));
      directed.push_back(make_row(make_req(MODE_PALETTE, 0, 0, 0), 1, 24'hFF0080, 0, 1));
      directed.push_back(make_row(make_req(MODE_PALETTE, 0, 0, 12'hFFF), 1, 0, 0, 1));
      directed.push_back(make_row(make_req(MODE_INDEX, 0, 0, 0), 1, 0, 0, 1));
      directed.push_back(make_row(make_req(MODE_LOAD, 24'h0A141E, 0, 0), 0, 0, 0, 0));
      directed.push_back(make_row(make_req(MODE_LOAD, 24'h0A141E, 0, 0), 0, 0, 0, 0));
      directed.push_back(make_row(make_req(MODE_LOAD, 24'h0A141E, 1, 0), 0, 0, 0, 0));
      directed.push_back(make_row(make_req(MODE_INDEX, 0, 0, 0), 0, 0, 0, 0));
      directed.push_back(make_row(make_req(MODE_INDEX, 0, 0, 2), 0, 0, 0, 0));
      directed.push_back(make_row(make_req(MODE_PALETTE, 0, 0, 2), 0, 0, 0, 0));
      foreach (directed[i]) send_request(directed[i].request, directed[i].typed,
                                         directed[i].result);

      image = 0;
      while (items < TARGET_ITEMS) begin
         idle_pct = (items < 330) ? 21 : (items < 640) ? 76 : 0;
         if (image % 3 == 0) write_colors_cap((image % 21 == 0) ? 9'($urandom_range(0, 511))
                                              : cap_choices[(image / 3) % 7]);
         if (image == 10) drain_results();
         n = ($urandom_range(0, 15) == 0) ? $urandom_range(24, 40) : $urandom_range(1, 10);
         style = $urandom_range(0, 2);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_request(make_req($urandom_range(0, 1) ? 2'd3 : MODE_INDEX, $urandom(),
                                     $urandom_range(0, 1), $urandom()), 0, '0);
            send_request(make_req(MODE_LOAD, random_color(style), i == n - 1, $urandom()),
                         0, '0);
         end
         reads = $urandom_range(2, 8);
         for (int i = 0; i < reads; i++) begin
            if ($urandom_range(0, 1)) begin
               addr = ($urandom_range(0, 7) == 0) ? 12'($urandom())
                                                  : 12'($urandom_range(0, color_total + 1));
               send_request(make_req(MODE_PALETTE, $urandom(), $urandom_range(0, 1), addr),
                            0, '0);
            end else begin
               addr = ($urandom_range(0, 7) == 0) ? 12'($urandom())
                                                  : 12'($urandom_range(0, pixels_cut + 1));
               send_request(make_req(MODE_INDEX, $urandom(), $urandom_range(0, 1), addr),
                            0, '0);
            end
         end
         image++;
      end

      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
